/* hw/rtl/source_blocklist_drop_counter_defines.svh */
// ----------------------------------------------------------------------------
// Blocklist drop counter assertion macros
// Shared assertion wrappers, clocked on the rising edge and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef SOURCE_BLOCKLIST_DROP_COUNTER_DEFINES_SVH
`define SOURCE_BLOCKLIST_DROP_COUNTER_DEFINES_SVH

// Assertion on an explicit clock and active-low reset
`define SBDC_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock and reset
`define SBDC_ASSERT(label, prop, msg) \
  `SBDC_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* hw/rtl/sbdc_pkg.sv */
// ----------------------------------------------------------------------------
// Blocklist drop counter package
// Table sizing, header check constants, stream layout and controller states.
// ----------------------------------------------------------------------------
package sbdc_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = IDX_W + 1;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned IN_W    = 96;
  localparam int unsigned OUT_W   = 40;

  localparam logic [15:0]        ETH_HDR_BYTES   = 16'd14;
  localparam logic [15:0]        IPV4_MIN_FRAME  = 16'd34;
  localparam logic [15:0]        ETHERTYPE_IPV4  = 16'h0800;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;
  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 32'd100;

  localparam logic MODE_CLASSIFY = 1'b0;
  localparam logic MODE_INSERT   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_UPD  = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

endpackage

/* hw/rtl/sbdc_ram.sv */
// ----------------------------------------------------------------------------
// Blocklist drop counter RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbdc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* hw/rtl/source_blocklist_drop_counter.sv */
// A packet-mode word that skips the lookup (short, non-IPv4 or truncated frame)
// goes straight to the done state; every other word scans the key RAM from slot 0
// to a hit or the last slot, a packet hit passing the update state on its way.
// One word is in flight, set by the linear scan of the key RAM read port; the next
// word is taken in the cycle after its result loads, later while tready is low.
// Reset clears all valid marks in flip-flops at once, threshold returns to 100.
// ----------------------------------------------------------------------------
// Source blocklist drop counter
// Exact-match IPv4 source blocklist with per-entry saturating drop counters.
// ----------------------------------------------------------------------------
`include "source_blocklist_drop_counter_defines.svh"

module source_blocklist_drop_counter
  import sbdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,     // drop_threshold
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // frame_length[15:0], ether_type[31:16], source_address[63:32],
  // initial_count[95:64]
  input  logic [IN_W-1:0]   s_axis_tdata_i,
  input  logic              s_axis_tuser_i,  // mode[0]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  // verdict[0], count_after[32:1], entry_removed[33], insert_failed[34],
  // zero[39:35]
  output logic [OUT_W-1:0]  m_axis_tdata_o
);

  state_e state_q, state_d;

  logic [COUNT_W-1:0]       thr_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  logic               mode_q;
  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] icount_q;

  logic [CNT_W-1:0] idx_q;
  logic             chk_q;
  logic [IDX_W-1:0] chk_idx_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;
  logic [IDX_W-1:0] slot_q;

  logic               res_verdict_q;
  logic [COUNT_W-1:0] res_count_q;
  logic               res_removed_q;
  logic               res_failed_q;

  logic             out_valid_q;
  logic [OUT_W-1:0] out_data_q;

  logic               s_fire;
  logic               m_fire;
  logic               eligible;
  logic               hit;
  logic               scan_last;
  logic               issue;
  logic               out_load;
  logic               key_we;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [KEY_W-1:0]   key_rdata;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [COUNT_W-1:0] cnt_inc;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire          = out_valid_q && m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // Packets need a full IPv4 header before the lookup; inserts always scan
  assign eligible = (s_axis_tuser_i == MODE_INSERT) ||
                    ((s_axis_tdata_i[15:0] >= ETH_HDR_BYTES) &&
                     (s_axis_tdata_i[31:16] == ETHERTYPE_IPV4) &&
                     (s_axis_tdata_i[15:0] >= IPV4_MIN_FRAME));

  assign issue     = (state_q == S_SCAN) && (idx_q < CNT_W'(TABLE_ENTRIES));
  assign hit       = chk_q && valid_q[chk_idx_q] && (key_rdata == key_q);
  assign scan_last = chk_q && (chk_idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign cnt_inc   = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + 1'b1;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || m_axis_tready_i);

  sbdc_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (key_rdata)
  );

  // Count read is addressed by the compared slot and lands in the cycle after the key
  // compare, so a hit finds its count waiting in the update state
  sbdc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (chk_idx_q),
    .rdata_o (cnt_rdata)
  );

  always_comb begin
    state_d   = state_q;
    key_we    = 1'b0;
    cnt_we    = 1'b0;
    cnt_waddr = chk_idx_q;
    cnt_wdata = icount_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          state_d = eligible ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (mode_q == MODE_INSERT) begin
            cnt_we  = 1'b1;
            state_d = S_DONE;
          end else begin
            state_d = S_UPD;
          end
        end else if (scan_last) begin
          if ((mode_q == MODE_INSERT) && free_found_q) begin
            key_we    = 1'b1;
            cnt_we    = 1'b1;
            cnt_waddr = free_idx_q;
          end
          state_d = S_DONE;
        end
      end
      S_UPD: begin
        cnt_we    = 1'b1;
        cnt_waddr = slot_q;
        cnt_wdata = cnt_inc;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      thr_q        <= THRESHOLD_RESET;
      valid_q      <= '0;
      chk_q        <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (s_fire) begin
        free_found_q <= 1'b0;
      end else if (issue && !valid_q[idx_q[IDX_W-1:0]]) begin
        free_found_q <= 1'b1;
      end
      chk_q <= issue;
      if (key_we) begin
        valid_q[free_idx_q] <= 1'b1;
      end
      // Drop the entry once its count passes the threshold
      if ((state_q == S_UPD) && (cnt_inc > thr_q)) begin
        valid_q[slot_q] <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      mode_q        <= s_axis_tuser_i;
      key_q         <= s_axis_tdata_i[63:32];
      icount_q      <= s_axis_tdata_i[95:64];
      idx_q         <= '0;
      res_verdict_q <= 1'b0;
      res_count_q   <= '0;
      res_removed_q <= 1'b0;
      res_failed_q  <= 1'b0;
    end
    if (issue) begin
      idx_q     <= idx_q + 1'b1;
      chk_idx_q <= idx_q[IDX_W-1:0];
      // Hold the lowest free slot seen so far
      if (!free_found_q && !valid_q[idx_q[IDX_W-1:0]]) begin
        free_idx_q <= idx_q[IDX_W-1:0];
      end
    end
    if ((state_q == S_SCAN) && hit) begin
      slot_q <= chk_idx_q;
    end
    if ((state_q == S_SCAN) && !hit && scan_last &&
        (mode_q == MODE_INSERT) && !free_found_q) begin
      res_failed_q <= 1'b1;
    end
    if (state_q == S_UPD) begin
      res_verdict_q <= 1'b1;
      res_count_q   <= cnt_inc;
      res_removed_q <= (cnt_inc > thr_q);
    end
    if (out_load) begin
      out_data_q <= {{(OUT_W - COUNT_W - 3){1'b0}}, res_failed_q, res_removed_q,
                     res_count_q, res_verdict_q};
    end
  end

  `SBDC_ASSERT(a_upd_after_scan, (state_q == S_UPD) |-> $past(state_q == S_SCAN),
               "update without a scan hit")
  `SBDC_ASSERT(a_fail_when_full,
               ((state_q == S_DONE) && res_failed_q) |->
               ((&valid_q) && (mode_q == MODE_INSERT)),
               "insert failure with a free slot")
  `SBDC_ASSERT(a_removed_is_drop, ((state_q == S_DONE) && res_removed_q) |-> res_verdict_q,
               "removal without a drop verdict")
  `SBDC_ASSERT(a_insert_free_slot,
               key_we |-> (!valid_q[free_idx_q] && (mode_q == MODE_INSERT)),
               "insert into an occupied slot")

endmodule
